// File: hw/rtl/scfp_pkg.sv
// shared types and constants for the serial command frame parser
package scfp_pkg;

	localparam int BYTE_W          = 8;
	localparam int PAYLOAD_W       = 64;
	localparam int STATUS_W        = 2;
	localparam int POS_W           = 9;
	localparam int CFG_IDX_W       = 1;
	localparam int PAYLOAD_MAX_DEF = 8;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h01;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h04;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_END = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_CMD  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    command_code;
		logic [BYTE_W-1:0]    payload_length;
		logic [PAYLOAD_W-1:0] payload_bytes;
		logic [STATUS_W-1:0]  frame_status;
	} frame_t;

endpackage

// File: hw/rtl/scfp_byte_if.sv
// valid/ready channel carrying one received serial byte
interface scfp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [scfp_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/scfp_frame_if.sv
// valid/ready channel carrying one parsed frame result
interface scfp_frame_if;
	logic                           valid;
	logic                           ready;
	logic [scfp_pkg::BYTE_W-1:0]    command_code;
	logic [scfp_pkg::BYTE_W-1:0]    payload_length;
	logic [scfp_pkg::PAYLOAD_W-1:0] payload_bytes;
	logic [scfp_pkg::STATUS_W-1:0]  frame_status;

	modport source (output valid, output command_code, output payload_length,
		output payload_bytes, output frame_status, input ready);
	modport sink   (input valid, input command_code, input payload_length,
		input payload_bytes, input frame_status, output ready);
endinterface

// File: hw/rtl/serial_command_frame_parser_core.sv
// serial command frame parser top level: input register, parser, result register
// Takes one received byte per beat on in_beat and parses frames made of a start
// byte, a length byte L, a command byte, L payload bytes and an end byte; bytes
// outside a frame are dropped. The byte in the end position yields one result on
// out_frame: status good with the packed payload, truncated when L exceeds
// PAYLOAD_MAX (the first PAYLOAD_MAX bytes are kept), or bad end with a zero
// payload. Each beat is held in the input register and parsed in a single
// pass into the result register, so the block takes one byte every cycle
// while the result register has room; an end byte's result goes from the
// input register into the result register. The result register holds a
// result until it is taken, while the input register still takes one more
// byte. The user must write start_byte (index 0) and end_byte (index 1) via
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce this.
module serial_command_frame_parser_core #(
	parameter int PAYLOAD_MAX = scfp_pkg::PAYLOAD_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	scfp_byte_if.sink                      in_beat,
	scfp_frame_if.source                   out_frame,
	input  logic                           cfg_we,
	input  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scfp_pkg::BYTE_W-1:0]    cfg_wdata
);
	import scfp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              in_ready;
	logic              res_valid;
	frame_t            res;
	logic              out_valid_q;
	frame_t            out_q;
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] end_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_wdata;
				REG_END_BYTE:   end_byte_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// parse the held beat only when the result register has room
	assign advance  = valid_s1 && (!out_valid_q || out_frame.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_beat.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_beat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_beat.valid) begin
			byte_s1 <= in_beat.rx_byte;
		end
	end

	scfp_parser #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.start_byte (start_byte_q),
		.end_byte   (end_byte_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_frame.valid          = out_valid_q;
	assign out_frame.command_code   = out_q.command_code;
	assign out_frame.payload_length = out_q.payload_length;
	assign out_frame.payload_bytes  = out_q.payload_bytes;
	assign out_frame.frame_status   = out_q.frame_status;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a beat while stalled");

	a_no_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid_q || out_frame.ready)
		else $error("result produced while result register full");

	a_bad_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_status == ST_BAD_END |-> out_q.payload_bytes == '0)
		else $error("dropped frame carries payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.frame_status == ST_GOOD || out_q.frame_status == ST_BAD_END
			|| out_q.frame_status == ST_TRUNC)
		else $error("undefined frame status");
`endif

endmodule

// File: hw/rtl/scfp_parser.sv
// frame parsing state machine with the payload byte store
module scfp_parser #(
	parameter int PAYLOAD_MAX = scfp_pkg::PAYLOAD_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [scfp_pkg::BYTE_W-1:0] rx_byte,
	input  logic [scfp_pkg::BYTE_W-1:0] start_byte,
	input  logic [scfp_pkg::BYTE_W-1:0] end_byte,
	output logic                        res_valid,
	output scfp_pkg::frame_t            res
);
	import scfp_pkg::*;

	localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [BYTE_W-1:0]   len_q, len_d;
	logic [BYTE_W-1:0]   cmd_q, cmd_d;
	logic [BYTE_W-1:0]   store_q [PAYLOAD_MAX];
	logic                store_we;
	logic [IDX_W-1:0]    store_idx;
	logic                more_body;
	logic [PAYLOAD_W-1:0] packed_payload;

	assign more_body = pos_q < {1'b0, len_q};
	assign store_idx = pos_q[IDX_W-1:0];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			unique case (phase_q)
				PH_HUNT: if (rx_byte == start_byte) phase_d = PH_LEN;
				PH_LEN:  phase_d = PH_CMD;
				PH_CMD:  phase_d = PH_BODY;
				PH_BODY: if (!more_body) phase_d = PH_HUNT;
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// stored bytes past the kept length read as zero
	always_comb begin
		packed_payload = '0;
		for (int i = 0; i < PAYLOAD_MAX; i++) begin
			if (BYTE_W'(i) < len_q) begin
				packed_payload[BYTE_W*i +: BYTE_W] = store_q[i];
			end
		end
	end

	// datapath updates and result
	always_comb begin
		pos_d     = pos_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		store_we  = 1'b0;
		res_valid = 1'b0;
		res.command_code   = cmd_q;
		res.payload_length = len_q;
		res.payload_bytes  = packed_payload;
		res.frame_status   = (len_q > BYTE_W'(PAYLOAD_MAX)) ? ST_TRUNC : ST_GOOD;
		if (rx_byte != end_byte) begin
			res.payload_bytes = '0;
			res.frame_status  = ST_BAD_END;
		end
		if (step) begin
			unique case (phase_q)
				PH_HUNT: ;
				PH_LEN:  len_d = rx_byte;
				PH_CMD: begin
					cmd_d = rx_byte;
					pos_d = '0;
				end
				PH_BODY: begin
					if (more_body) begin
						store_we = pos_q < POS_W'(PAYLOAD_MAX);
						pos_d    = pos_q + 1'b1;
					end else begin
						res_valid = 1'b1;
						pos_d     = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[store_idx] <= rx_byte;
		end
	end

endmodule
